/* rtl/core/gctp_pkg.sv */
package gctp_pkg;

	localparam int FREQ_W = 24;
	localparam int AMP_W = 8;
	localparam int SHAPE_W = 2;
	localparam int CHAR_W = 8;
	localparam int DIGIT_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [FREQ_W-1:0] MAX_FREQ_RESET = 24'd12500000;
	localparam logic [FREQ_W-1:0] FREQ_TOP = '1;
	localparam logic [AMP_W-1:0] AMP_TOP = '1;

	// register index of max_frequency, taken from paddr[2]
	localparam logic REG_MAX_FREQUENCY = 1'b0;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CHAR_SEMI = 8'h3B;
	localparam logic [CHAR_W-1:0] CHAR_BANG = 8'h21;

	localparam logic [SHAPE_W-1:0] SHAPE_SINE = 2'd0;
	localparam logic [DIGIT_W-1:0] SHAPE_LIMIT = 4'd3;

	typedef enum logic [1:0] {
		FIELD_FREQ  = 2'd0,
		FIELD_AMP   = 2'd1,
		FIELD_SHAPE = 2'd2,
		FIELD_DONE  = 2'd3
	} field_t;

	typedef struct packed {
		logic [FREQ_W-1:0]  frequency_hz;
		logic [AMP_W-1:0]   amplitude_level;
		logic [SHAPE_W-1:0] wave_shape;
		logic               frequency_taken;
		logic               amplitude_taken;
		logic               shape_taken;
	} result_t;

endpackage

/* rtl/core/gctp_byte_if.sv */
interface gctp_byte_if
	import gctp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/core/gctp_result_if.sv */
interface gctp_result_if
	import gctp_pkg::*;
();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/generator_command_text_parser_unit.sv */
// Command text parser for a signal generator. Feed it received characters one
// per beat on cmd_in; it assembles commands of the form freq:amp:shape; and on
// each ';' puts out one result beat on result holding the settings as they stand
// after that command, with a taken flag for each setting the command wrote.
// Bytes other than digits, ':', ';' and '!' are dropped; '!' discards a partial
// command. A beat can be accepted in every cycle unless cmd_in stalls: each
// character is held in the input register and parsed there, a digit by one
// multiply-by-ten-and-add, and a ';' moves on from the input register into the
// result register. cmd_in stalls only when a ';' waits in the input register
// while the result register still holds an untaken beat.
// max_frequency (reset 12500000) sits at APB byte address 0; write it only
// while the block is idle.
module generator_command_text_parser_unit
	import gctp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	gctp_byte_if.sink             cmd_in,
	gctp_result_if.source         result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	// configuration
	logic [FREQ_W-1:0] max_freq_q;

	// input register
	logic              valid_s1;
	logic [CHAR_W-1:0] byte_s1;

	// parse state
	field_t             field_q;
	logic [FREQ_W-1:0]  freq_acc_q;
	logic               freq_ovf_q;
	logic [AMP_W-1:0]   amp_acc_q;
	logic               amp_ovf_q;
	logic               shape_seen_q;
	logic [DIGIT_W-1:0] shape_char_q;

	// settings
	logic [FREQ_W-1:0]  cur_freq_q;
	logic [AMP_W-1:0]   cur_amp_q;
	logic [SHAPE_W-1:0] cur_shape_q;

	// result register
	logic    res_valid_q;
	result_t res_q;

	// next-state wires
	field_t             field_d;
	logic [FREQ_W-1:0]  freq_acc_d;
	logic               freq_ovf_d;
	logic [AMP_W-1:0]   amp_acc_d;
	logic               amp_ovf_d;
	logic               shape_seen_d;
	logic [DIGIT_W-1:0] shape_char_d;
	logic [FREQ_W-1:0]  cur_freq_d;
	logic [AMP_W-1:0]   cur_amp_d;
	logic [SHAPE_W-1:0] cur_shape_d;
	result_t            res_d;

	logic               is_digit;
	logic               is_semi;
	logic [DIGIT_W-1:0] digit;
	logic [FREQ_W+3:0]  freq_mac;
	logic [AMP_W+3:0]   amp_mac;
	logic [DIGIT_W-1:0] shape_pick;
	logic               advance_s1;
	logic               cfg_write;

	// ---------------------------------------------------------------- APB
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_freq_q <= MAX_FREQ_RESET;
		end else if (cfg_write && paddr[2] == REG_MAX_FREQUENCY) begin
			max_freq_q <= pwdata[FREQ_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_MAX_FREQUENCY) begin
			prdata = {{(APB_DATA_W-FREQ_W){1'b0}}, max_freq_q};
		end
	end

	// ---------------------------------------------------------- handshake
	// A ';' needs a free result register; every other character just retires.
	assign is_semi    = (byte_s1 == CHAR_SEMI);
	assign advance_s1 = valid_s1 && (!is_semi || !res_valid_q || result.ready);
	assign cmd_in.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_in.ready) begin
			valid_s1 <= cmd_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_in.ready && cmd_in.valid) begin
			byte_s1 <= cmd_in.rx_byte;
		end
	end

	// -------------------------------------------------------------- parse
	assign is_digit = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	assign digit    = DIGIT_W'(byte_s1 - CHAR_ZERO);

	// acc * 10 + digit as (acc << 3) + (acc << 1) + digit, four spare bits
	assign freq_mac = {1'b0, freq_acc_q, 3'b000} + {3'b000, freq_acc_q, 1'b0}
		+ {{FREQ_W{1'b0}}, digit};
	assign amp_mac = {1'b0, amp_acc_q, 3'b000} + {3'b000, amp_acc_q, 1'b0}
		+ {{AMP_W{1'b0}}, digit};

	// a missing shape field reads as sine
	assign shape_pick = shape_seen_q ? shape_char_q : {DIGIT_W{1'b0}};

	always_comb begin
		field_d      = field_q;
		freq_acc_d   = freq_acc_q;
		freq_ovf_d   = freq_ovf_q;
		amp_acc_d    = amp_acc_q;
		amp_ovf_d    = amp_ovf_q;
		shape_seen_d = shape_seen_q;
		shape_char_d = shape_char_q;
		cur_freq_d   = cur_freq_q;
		cur_amp_d    = cur_amp_q;
		cur_shape_d  = cur_shape_q;
		res_d        = '0;

		priority if (is_digit) begin
			unique case (field_q)
				FIELD_FREQ: begin
					// saturate once the value leaves 24 bits, and stay there
					if (freq_ovf_q || freq_mac[FREQ_W+3:FREQ_W] != 4'd0) begin
						freq_ovf_d = 1'b1;
						freq_acc_d = FREQ_TOP;
					end else begin
						freq_acc_d = freq_mac[FREQ_W-1:0];
					end
				end
				FIELD_AMP: begin
					if (amp_ovf_q || amp_mac[AMP_W+3:AMP_W] != 4'd0) begin
						amp_ovf_d = 1'b1;
						amp_acc_d = AMP_TOP;
					end else begin
						amp_acc_d = amp_mac[AMP_W-1:0];
					end
				end
				FIELD_SHAPE: begin
					// only the first shape character counts
					if (!shape_seen_q) begin
						shape_seen_d = 1'b1;
						shape_char_d = digit;
					end
					field_d = FIELD_DONE;
				end
				FIELD_DONE: begin
				end
				default: begin
				end
			endcase
		end else if (byte_s1 == CHAR_COLON) begin
			if (field_q != FIELD_DONE) begin
				field_d = field_t'(field_q + 2'd1);
			end
		end else if (byte_s1 == CHAR_BANG) begin
			field_d      = FIELD_FREQ;
			freq_acc_d   = '0;
			freq_ovf_d   = 1'b0;
			amp_acc_d    = '0;
			amp_ovf_d    = 1'b0;
			shape_seen_d = 1'b0;
			shape_char_d = '0;
		end else if (is_semi) begin
			// execute the command, then clear the parse state
			if (!freq_ovf_q && freq_acc_q != '0 && freq_acc_q <= max_freq_q) begin
				cur_freq_d            = freq_acc_q;
				res_d.frequency_taken = 1'b1;
			end
			if (!amp_ovf_q && amp_acc_q != '0) begin
				cur_amp_d             = amp_acc_q;
				res_d.amplitude_taken = 1'b1;
			end
			if (shape_pick < SHAPE_LIMIT) begin
				cur_shape_d       = shape_pick[SHAPE_W-1:0];
				res_d.shape_taken = 1'b1;
			end
			field_d      = FIELD_FREQ;
			freq_acc_d   = '0;
			freq_ovf_d   = 1'b0;
			amp_acc_d    = '0;
			amp_ovf_d    = 1'b0;
			shape_seen_d = 1'b0;
			shape_char_d = '0;
		end else begin
			// drop anything else
		end

		res_d.frequency_hz    = cur_freq_d;
		res_d.amplitude_level = cur_amp_d;
		res_d.wave_shape      = cur_shape_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q      <= FIELD_FREQ;
			freq_acc_q   <= '0;
			freq_ovf_q   <= 1'b0;
			amp_acc_q    <= '0;
			amp_ovf_q    <= 1'b0;
			shape_seen_q <= 1'b0;
			shape_char_q <= '0;
			cur_freq_q   <= '0;
			cur_amp_q    <= '0;
			cur_shape_q  <= SHAPE_SINE;
		end else if (advance_s1) begin
			field_q      <= field_d;
			freq_acc_q   <= freq_acc_d;
			freq_ovf_q   <= freq_ovf_d;
			amp_acc_q    <= amp_acc_d;
			amp_ovf_q    <= amp_ovf_d;
			shape_seen_q <= shape_seen_d;
			shape_char_q <= shape_char_d;
			cur_freq_q   <= cur_freq_d;
			cur_amp_q    <= cur_amp_d;
			cur_shape_q  <= cur_shape_d;
		end
	end

	// ----------------------------------------------------- result register
	// Load on a retiring ';', drop the beat once it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance_s1 && is_semi) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && is_semi) begin
			res_q <= res_d;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

/* rtl/core/gctp_checker.sv */
module gctp_checker
	import gctp_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input result_t            res_data,
	input logic               pready
);

	// a result beat waits until it is taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped before it was taken");

	a_shape_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.wave_shape != 2'd3)
		else $error("wave_shape carries an undefined code");

	a_freq_taken: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.frequency_taken |-> res_data.frequency_hz != '0)
		else $error("frequency written as zero");

	a_amp_taken: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.amplitude_taken |-> res_data.amplitude_level != '0)
		else $error("amplitude written as zero");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("APB wait state inserted");

endmodule

bind generator_command_text_parser_unit gctp_checker u_gctp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data),
	.pready    (pready)
);

/* tb/gctp_settings_checker.sv */
`timescale 1ns / 1ps
module gctp_settings_checker
	import gctp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	gctp_byte_if                  cmd_in,
	gctp_result_if                result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output int                    fail_count,
	output int                    settings_pending
);

	logic [FREQ_W-1:0]  freq_limit;
	field_t             field;
	logic [FREQ_W-1:0]  freq_acc;
	logic               freq_ovf;
	logic [AMP_W-1:0]   amp_acc;
	logic               amp_ovf;
	logic               shape_seen;
	logic [DIGIT_W-1:0] shape_digit;
	logic [FREQ_W-1:0]  freq_now;
	logic [AMP_W-1:0]   amp_now;
	logic [SHAPE_W-1:0] shape_now;
	result_t            settings_due[$];
	int                 mismatches = 0;
	int                 pending_count = 0;

	assign fail_count = mismatches;
	assign settings_pending = pending_count;

	function automatic void clear_command();
		field = FIELD_FREQ;
		freq_acc = '0;
		freq_ovf = 1'b0;
		amp_acc = '0;
		amp_ovf = 1'b0;
		shape_seen = 1'b0;
		shape_digit = '0;
	endfunction

	// {overflow, value}: multiply by ten, add the digit, stick at top once past it
	function automatic logic [32:0] saturate_add(input logic [31:0] acc, input logic ovf,
			input logic [31:0] top, input logic [DIGIT_W-1:0] digit);
		logic [35:0] sum;
		sum = 36'(acc) * 36'd10 + 36'(digit);
		if (ovf || sum > 36'(top))
			return {1'b1, top};
		return {1'b0, sum[31:0]};
	endfunction

	// advance the command parse by one character; returns 1 when a result is due
	function automatic bit parse_char(input logic [CHAR_W-1:0] c, output result_t res);
		logic [32:0]        acc;
		logic [DIGIT_W-1:0] digit;
		logic [DIGIT_W-1:0] shape_code;
		res = '0;
		digit = DIGIT_W'(c - CHAR_ZERO);
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			case (field)
			FIELD_FREQ: begin
				acc = saturate_add(32'(freq_acc), freq_ovf, 32'(FREQ_TOP), digit);
				freq_ovf = acc[32];
				freq_acc = acc[FREQ_W-1:0];
			end
			FIELD_AMP: begin
				acc = saturate_add(32'(amp_acc), amp_ovf, 32'(AMP_TOP), digit);
				amp_ovf = acc[32];
				amp_acc = acc[AMP_W-1:0];
			end
			FIELD_SHAPE: begin
				if (!shape_seen) begin
					shape_seen = 1'b1;
					shape_digit = digit;
				end
				field = FIELD_DONE;
			end
			default: ;
			endcase
			return 1'b0;
		end
		if (c == CHAR_COLON) begin
			if (field != FIELD_DONE)
				field = field_t'(field + 2'd1);
			return 1'b0;
		end
		if (c == CHAR_BANG) begin
			clear_command();
			return 1'b0;
		end
		if (c != CHAR_SEMI)
			return 1'b0;

		if (!freq_ovf && freq_acc != '0 && freq_acc <= freq_limit) begin
			freq_now = freq_acc;
			res.frequency_taken = 1'b1;
		end
		if (!amp_ovf && amp_acc != '0) begin
			amp_now = amp_acc;
			res.amplitude_taken = 1'b1;
		end
		shape_code = shape_seen ? shape_digit : '0;
		if (shape_code < SHAPE_LIMIT) begin
			shape_now = shape_code[SHAPE_W-1:0];
			res.shape_taken = 1'b1;
		end
		clear_command();
		res.frequency_hz = freq_now;
		res.amplitude_level = amp_now;
		res.wave_shape = shape_now;
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			freq_limit = MAX_FREQ_RESET;
			clear_command();
			freq_now = '0;
			amp_now = '0;
			shape_now = '0;
			settings_due.delete();
		end else begin
			// compare before the new beat is parsed, so a result put out without registering its ';' cannot hide
			if (result.valid && result.ready) begin
				if (settings_due.size() == 0) begin
					$display("%0t: result beat with no command pending: expected none, got %p",
						$time, result.data);
					mismatches++;
				end else begin
					want = settings_due.pop_front();
					check_field("frequency_hz", 32'(want.frequency_hz),
						32'(result.data.frequency_hz));
					check_field("amplitude_level", 32'(want.amplitude_level),
						32'(result.data.amplitude_level));
					check_field("wave_shape", 32'(want.wave_shape), 32'(result.data.wave_shape));
					check_field("frequency_taken", 32'(want.frequency_taken),
						32'(result.data.frequency_taken));
					check_field("amplitude_taken", 32'(want.amplitude_taken),
						32'(result.data.amplitude_taken));
					check_field("shape_taken", 32'(want.shape_taken),
						32'(result.data.shape_taken));
				end
			end
			if (cmd_in.valid && cmd_in.ready) begin
				if (parse_char(cmd_in.rx_byte, want))
					settings_due.push_back(want);
			end
			if (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1:2] == REG_MAX_FREQUENCY)
				freq_limit = pwdata[FREQ_W-1:0];
		end
		pending_count = settings_due.size();
	end

endmodule

/* tb/generator_command_text_parser_unit_tb.sv */
`timescale 1ns / 1ps
module generator_command_text_parser_unit_tb;
	import gctp_pkg::*;

	// meaningful beats (digits, ':', ';', '!') to send in the random part
	localparam int BEAT_TARGET = 1200;
	localparam int PHASES = 6;
	// a ';' passes through the input register into the result register; leave margin
	localparam int SETTLE_CYCLES = 8;
	// worst case is roughly 1800 beats, each behind a send gap and a result stall; take it several times
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [APB_ADDR_W-1:0] MAX_FREQUENCY_ADDR = APB_ADDR_W'(REG_MAX_FREQUENCY) << 2;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int                    cycle_count = 0;
	int                    fail_count;
	int                    settings_pending;
	int                    counted_beats = 0;
	int                    tx_mode = 0;
	int                    rx_mode = 0;
	logic [FREQ_W-1:0]     freq_limit_now;
	logic [CHAR_W-1:0]     cmd_chars[$];

	gctp_byte_if   cmd_if();
	gctp_result_if res_if();

	generator_command_text_parser_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_in  (cmd_if.sink),
		.result  (res_if.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	gctp_settings_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_in           (cmd_if),
		.result           (res_if),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.pready           (pready),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.fail_count       (fail_count),
		.settings_pending (settings_pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends here.
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("generator_command_text_parser_unit_tb: FAIL");
		$finish;
	end

	function automatic bit is_token(input logic [CHAR_W-1:0] c);
		return (c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_COLON || c == CHAR_SEMI ||
			c == CHAR_BANG;
	endfunction

	// Idle modes: 0 never waits, 1 waits a drawn gap every time, 2 waits now and then.
	// Modes switch at random so long bursts and heavy stalling both show up.
	function automatic int draw_gap(input int mode);
		case (mode)
		0: return 0;
		1: return $urandom_range(0, 17);
		default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
		endcase
	endfunction

	// Offer one character beat and hold it until taken. valid stays high into the
	// next beat when no gap is drawn, so it is never dropped and raised in one step.
	task automatic send_byte(input logic [CHAR_W-1:0] c);
		int gap;
		gap = draw_gap(tx_mode);
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.rx_byte <= c;
		do @(posedge clk); while (!cmd_if.ready);
		if (is_token(c))
			counted_beats++;
		if ($urandom_range(0, 63) == 0)
			tx_mode = $urandom_range(0, 2);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			cmd_chars.push_back(s[i]);
	endtask

	function automatic logic [CHAR_W-1:0] noise_char();
		logic [CHAR_W-1:0] c;
		do c = CHAR_W'($urandom_range(0, 255)); while (is_token(c));
		return c;
	endfunction

	// Drop valid, wait for every expected result, then let the pipe settle so a
	// character that makes no result has also left the block.
	task automatic drain();
		cmd_if.valid <= 1'b0;
		@(negedge clk);
		while (settings_pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_frequency(input logic [FREQ_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MAX_FREQUENCY_ADDR;
		pwdata <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		freq_limit_now = value;
	endtask

	// Frequency text aimed around the current limit, plus zero, overflow and empty.
	function automatic string freq_text();
		case ($urandom_range(0, 9))
		0: return "0";
		1: return $sformatf("%0d", freq_limit_now);
		2: return $sformatf("%0d", 32'(freq_limit_now) + 32'd1);
		3: return $sformatf("%0d", $urandom_range(16777216, 99999999));
		4: return $sformatf("%0d%0d", $urandom_range(100000, 999999),
			$urandom_range(100000, 999999));
		5: return $sformatf("%0d", $urandom_range(1, 32'h00FF_FFFF));
		6: return "";
		7: return $sformatf("00%0d", $urandom_range(1, 999));
		default: return $sformatf("%0d",
			(freq_limit_now > 1) ? $urandom_range(1, 32'(freq_limit_now)) : 1);
		endcase
	endfunction

	function automatic string amp_text();
		case ($urandom_range(0, 9))
		0: return "0";
		1: return "255";
		2: return "256";
		3: return $sformatf("%0d", $urandom_range(257, 99999));
		4: return "";
		5: return $sformatf("0%0d", $urandom_range(1, 255));
		default: return $sformatf("%0d", $urandom_range(1, 255));
		endcase
	endfunction

	// Shape text: mostly the three known codes, some unknown digits, trailing
	// characters that must be ignored, and a leading extra colon.
	function automatic string shape_text();
		case ($urandom_range(0, 9))
		0: return "";
		1: return $sformatf("%0d", $urandom_range(3, 9));
		2: return $sformatf("%0d%0d", $urandom_range(0, 9), $urandom_range(0, 99));
		3: return {":", $sformatf("%0d", $urandom_range(0, 9))};
		default: return $sformatf("%0d", $urandom_range(0, 2));
		endcase
	endfunction

	// One random command: mostly well formed with random content, some with fields
	// missing, some corrupted by noise, a '!' or a lost ';', and some raw garbage.
	task automatic send_command();
		string f;
		string a;
		string s;
		if ($urandom_range(0, 99) < 10) begin
			repeat ($urandom_range(1, 12)) send_byte(CHAR_W'($urandom_range(0, 255)));
			return;
		end
		f = freq_text();
		a = amp_text();
		s = shape_text();
		cmd_chars.delete();
		case ($urandom_range(0, 11))
		0: push_text({f, ";"});
		1: push_text({f, ":", a, ";"});
		2: push_text(";");
		default: push_text({f, ":", a, ":", s, ";"});
		endcase
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 3))
				cmd_chars.insert($urandom_range(0, cmd_chars.size() - 1), noise_char());
		end
		if ($urandom_range(0, 11) == 0)
			cmd_chars.insert($urandom_range(0, cmd_chars.size() - 1), CHAR_BANG);
		if ($urandom_range(0, 24) == 0)
			void'(cmd_chars.pop_back());
		foreach (cmd_chars[i])
			send_byte(cmd_chars[i]);
	endtask

	// Result side: before each beat, drop ready for a gap drawn in the current mode,
	// then hold ready until a beat is taken.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(rx_mode);
			if (gap > 0) begin
				res_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
			if ($urandom_range(0, 31) == 0)
				rx_mode = $urandom_range(0, 2);
		end
	end

	initial begin
		int base;
		logic [FREQ_W-1:0] limit;
		cmd_if.valid = 1'b0;
		cmd_if.rx_byte = '0;
		res_if.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		freq_limit_now = MAX_FREQ_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, under the reset limit.
		// Frequency at the limit, largest amplitude, triangle.
		send_text("12500000:255:2;");
		// Dropped bytes: both extremes of the character range.
		send_byte(8'h00);
		send_byte(8'hFF);
		// Both numeric fields overflow; the missing shape field reads as sine.
		send_text("16777216:256;");
		// Discard a partial command, then an empty one: nothing taken but shape.
		send_text("7:9!;");
		// Extra colon leaves the shape field empty; later digits are ignored.
		send_text("1:1::19;");
		// Frequency just past the limit, zero amplitude, unknown shape digit.
		send_text("12500001:0:93;");
		// Zero frequency, square.
		send_text("0:1:1;");

		// Random part: several limit settings, the extremes and zero among them.
		base = counted_beats;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
			0: limit = FREQ_TOP;
			1: limit = 24'd1;
			2: limit = '0;
			3: limit = FREQ_W'($urandom_range(2, 1000));
			4: limit = FREQ_W'($urandom_range(1, 32'h00FF_FFFF));
			default: limit = MAX_FREQ_RESET;
			endcase
			drain();
			write_max_frequency(limit);
			while (counted_beats - base < (phase + 1) * BEAT_TARGET / PHASES)
				send_command();
		end

		drain();
		if (fail_count == 0)
			$display("generator_command_text_parser_unit_tb: PASS");
		else
			$display("generator_command_text_parser_unit_tb: FAIL");
		$finish;
	end

endmodule
